### sv/atic_pkg.sv
// shared types, widths and the timer reload calculation
`timescale 1ns / 1ps
package atic_pkg;

  localparam int RELOAD_W = 24;   // holds 65536 * 255 and any line length up to 1024
  localparam int INTERVAL_W = 16;

  localparam int CYCLES_PER_LINE_DEF = 114;
  localparam int MULT_64K_DEF = 28;
  localparam int MULT_15K_DEF = 114;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef struct packed {
    logic [15:0] cassette_delay;
    logic [7:0]  serial_in_byte;
    logic [7:0]  write_data;
    logic [3:0]  address;
    op_t         op;
  } item_t;

  typedef struct packed {
    logic [7:0] send_byte;
    logic       send_valid;
    logic       irq;
    logic [7:0] read_data;
  } result_t;

  typedef struct packed {
    logic load;     // take a new reload value
    logic stimer;   // restart count from reload
    logic tick;     // one scanline passes
  } timer_ctl_t;

  // reload for one timer; a paired timer uses hi:lo, a single one lo only
  function automatic logic [RELOAD_W-1:0] calc_reload(
    input logic [7:0]          hi,
    input logic [7:0]          lo,
    input logic                pair,
    input logic                fast,
    input logic [7:0]          base,
    input logic [RELOAD_W-1:0] cpl
  );
    logic [15:0]         operand;
    logic [16:0]         sum;
    logic [24:0]         prod;
    logic [RELOAD_W-1:0] v;
    operand = pair ? {hi, lo} : {8'h00, lo};
    if (!fast) begin
      sum = {1'b0, operand} + 17'd1;
    end else if (pair) begin
      sum = {1'b0, operand} + 17'd7;
    end else begin
      sum = {1'b0, operand} + 17'd4;
    end
    prod = fast ? {8'h00, sum} : 25'(sum) * 25'(base);
    v = prod[RELOAD_W-1:0];
    return (v < cpl) ? cpl : v;
  endfunction

endpackage

### sv/atic_timer.sv
// one interval timer: reload register and down counter in cpu cycles
`timescale 1ns / 1ps
module atic_timer #(
  parameter int CYCLES_PER_LINE = atic_pkg::CYCLES_PER_LINE_DEF,
  parameter logic [atic_pkg::RELOAD_W-1:0] RESET_RELOAD = atic_pkg::RELOAD_W'(114)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  atic_pkg::timer_ctl_t          ctl,
  input  logic [atic_pkg::RELOAD_W-1:0] reload_value,
  output logic                          due
);
  import atic_pkg::*;

  localparam logic [RELOAD_W-1:0] CPL = RELOAD_W'(CYCLES_PER_LINE);

  logic [RELOAD_W-1:0] reload;
  logic [RELOAD_W-1:0] count;
  logic [RELOAD_W:0]   wrap_sum;

  // fires on this line when less than one line of cycles is left
  assign due = (count < CPL);
  assign wrap_sum = {1'b0, count} + {1'b0, reload} - {1'b0, CPL};

  always_ff @(posedge clk) begin
    if (rst) begin
      reload <= RESET_RELOAD;
      count  <= '0;
    end else begin
      if (ctl.load) begin
        reload <= reload_value;
      end
      if (ctl.stimer) begin
        count <= reload;
      end else if (ctl.tick) begin
        count <= due ? wrap_sum[RELOAD_W-1:0] : count - CPL;
      end
    end
  end

endmodule

### sv/atic_core.sv
// register file, serial delays and irq status; one item per cycle while proc is high
`timescale 1ns / 1ps
module atic_core #(
  parameter int CYCLES_PER_LINE = atic_pkg::CYCLES_PER_LINE_DEF,
  parameter int MULT_64K = atic_pkg::MULT_64K_DEF,
  parameter int MULT_15K = atic_pkg::MULT_15K_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            proc,
  input  atic_pkg::item_t                 item,
  input  logic [atic_pkg::INTERVAL_W-1:0] serout_ivl,
  input  logic [atic_pkg::INTERVAL_W-1:0] xmtdone_ivl,
  output atic_pkg::result_t               result
);
  import atic_pkg::*;

  localparam logic [3:0] ADDR_AUDF1  = 4'h0;
  localparam logic [3:0] ADDR_AUDF2  = 4'h2;
  localparam logic [3:0] ADDR_AUDF3  = 4'h4;
  localparam logic [3:0] ADDR_AUDF4  = 4'h6;
  localparam logic [3:0] ADDR_AUDCTL = 4'h8;
  localparam logic [3:0] ADDR_STIMER = 4'h9;
  localparam logic [3:0] ADDR_SKRES  = 4'hA;
  localparam logic [3:0] ADDR_SEROUT = 4'hD;
  localparam logic [3:0] ADDR_IRQEN  = 4'hE;
  localparam logic [3:0] ADDR_SKCTL  = 4'hF;
  localparam logic [3:0] ADDR_SERIN  = 4'hD;
  localparam logic [3:0] ADDR_IRQST  = 4'hE;
  localparam logic [3:0] ADDR_SKSTAT = 4'hF;

  localparam logic [7:0] SPEED_A = 8'h28;
  localparam logic [7:0] SPEED_B = 8'h10;
  localparam logic [7:0] SPEED_C = 8'h08;
  localparam logic [7:0] SPEED_D = 8'h0A;
  localparam logic [7:0] SKCTL_MODE_MASK = 8'h70;
  localparam logic [7:0] SKCTL_MODE_SEND = 8'h20;
  localparam logic [7:0] AUDCTL_SPEED    = 8'h28;

  localparam logic [RELOAD_W-1:0] CPL = RELOAD_W'(CYCLES_PER_LINE);
  localparam logic [7:0] BASE_64K = 8'(MULT_64K);
  localparam logic [7:0] BASE_15K = 8'(MULT_15K);
  localparam logic [RELOAD_W-1:0] RESET_RELOAD =
    calc_reload(8'h00, 8'h00, 1'b0, 1'b0, BASE_64K, CPL);

  logic [7:0] freq [4];
  logic [7:0] audio, skctl, ien, irqst, skstat, serin_reg;
  logic       irq_line;
  logic [INTERVAL_W-1:0] serin_wait, serout_wait, xmtdone_wait;

  logic [7:0] freq_next [4];
  logic [7:0] audio_next, skctl_next, ien_next, irqst_next, skstat_next, serin_next;
  logic       irq_line_next;
  logic [INTERVAL_W-1:0] serin_wait_next, serout_wait_next, xmtdone_wait_next;

  timer_ctl_t          tctl;
  logic [2:0]          due;
  logic [RELOAD_W-1:0] reload_value [3];
  logic [7:0]          base;
  logic                speed_ok;

  // reloads follow the register values this item leaves behind
  always_comb begin
    base = audio_next[0] ? BASE_15K : BASE_64K;
    reload_value[0] = calc_reload(8'h00, freq_next[0], 1'b0, audio_next[6], base, CPL);
    reload_value[1] = calc_reload(freq_next[1], audio_next[4] ? freq_next[0] : freq_next[1],
                                  audio_next[4], audio_next[6] & audio_next[4], base, CPL);
    reload_value[2] = calc_reload(freq_next[3], audio_next[3] ? freq_next[2] : freq_next[3],
                                  audio_next[3], audio_next[5] & audio_next[3], base, CPL);
  end

  assign speed_ok = (freq[2] == SPEED_A || freq[2] == SPEED_B || freq[2] == SPEED_C ||
                     freq[2] == SPEED_D) && (freq[3] == 8'h00) &&
                    ((audio & AUDCTL_SPEED) == AUDCTL_SPEED);

  always_comb begin
    freq_next         = freq;
    audio_next        = audio;
    skctl_next        = skctl;
    ien_next          = ien;
    irqst_next        = irqst;
    skstat_next       = skstat;
    serin_next        = serin_reg;
    irq_line_next     = irq_line;
    serin_wait_next   = serin_wait;
    serout_wait_next  = serout_wait;
    xmtdone_wait_next = xmtdone_wait;
    tctl              = '0;
    result.read_data  = 8'hFF;
    result.send_valid = 1'b0;
    result.send_byte  = 8'h00;
    if (proc) begin
      case (item.op)
        OP_WRITE: begin
          case (item.address)
            ADDR_AUDF1, ADDR_AUDF2, ADDR_AUDF3, ADDR_AUDF4: begin
              freq_next[item.address[2:1]] = item.write_data;
              tctl.load = 1'b1;
            end
            ADDR_AUDCTL: begin
              audio_next = item.write_data;
              tctl.load  = 1'b1;
            end
            ADDR_STIMER: tctl.stimer = 1'b1;
            ADDR_SKRES: skstat_next = skstat | 8'hE0;
            ADDR_SEROUT: begin
              if ((skctl & SKCTL_MODE_MASK) == SKCTL_MODE_SEND && speed_ok) begin
                result.send_valid = 1'b1;
                result.send_byte  = item.write_data;
              end
              serout_wait_next  = serout_ivl;
              xmtdone_wait_next = xmtdone_ivl;
              irqst_next        = irqst | 8'h08;
            end
            ADDR_IRQEN: begin
              ien_next   = item.write_data;
              irqst_next = irqst | (~item.write_data & 8'hF7);
              if (item.write_data[5] && item.cassette_delay != '0) begin
                serin_wait_next = item.cassette_delay;
              end
              if ((~irqst_next & ien_next) == 8'h00) begin
                irq_line_next = 1'b0;
              end
            end
            ADDR_SKCTL: skctl_next = item.write_data;
            default: ;
          endcase
        end
        OP_READ: begin
          case (item.address)
            ADDR_SERIN:  result.read_data = serin_reg;
            ADDR_IRQST:  result.read_data = irqst;
            ADDR_SKSTAT: result.read_data = skstat;
            default:     result.read_data = 8'hFF;
          endcase
        end
        OP_TICK: begin
          tctl.tick = 1'b1;
          if (serin_wait != '0) begin
            serin_wait_next = serin_wait - INTERVAL_W'(1);
            if (serin_wait == INTERVAL_W'(1) && ien[5]) begin
              // a second byte before the first was acknowledged is an overrun
              if (irqst[5]) begin
                irqst_next[5] = 1'b0;
                serin_next    = item.serial_in_byte;
              end else begin
                skstat_next[5] = 1'b0;
              end
              irq_line_next = 1'b1;
            end
          end
          if (serout_wait != '0) begin
            serout_wait_next = serout_wait - INTERVAL_W'(1);
            if (serout_wait == INTERVAL_W'(1) && ien[4]) begin
              irqst_next[4] = 1'b0;
              irq_line_next = 1'b1;
            end
          end
          // transmit-done status drops even when its enable is off
          if (xmtdone_wait != '0) begin
            xmtdone_wait_next = xmtdone_wait - INTERVAL_W'(1);
            if (xmtdone_wait == INTERVAL_W'(1)) begin
              irqst_next[3] = 1'b0;
              if (ien[3]) begin
                irq_line_next = 1'b1;
              end
            end
          end
          for (int t = 0; t < 3; t++) begin
            if (due[t] && ien[t]) begin
              irqst_next[t] = 1'b0;
              irq_line_next = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    result.irq = irq_line_next;
  end

  for (genvar g = 0; g < 3; g++) begin : g_timer
    atic_timer #(
      .CYCLES_PER_LINE (CYCLES_PER_LINE),
      .RESET_RELOAD    (RESET_RELOAD)
    ) u_timer (
      .clk          (clk),
      .rst          (rst),
      .ctl          (tctl),
      .reload_value (reload_value[g]),
      .due          (due[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        freq[i] <= 8'h00;
      end
      audio        <= 8'h00;
      skctl        <= 8'h00;
      ien          <= 8'h00;
      irqst        <= 8'hFF;
      skstat       <= 8'hEF;
      serin_reg    <= 8'h00;
      irq_line     <= 1'b0;
      serin_wait   <= '0;
      serout_wait  <= '0;
      xmtdone_wait <= '0;
    end else begin
      freq         <= freq_next;
      audio        <= audio_next;
      skctl        <= skctl_next;
      ien          <= ien_next;
      irqst        <= irqst_next;
      skstat       <= skstat_next;
      serin_reg    <= serin_next;
      irq_line     <= irq_line_next;
      serin_wait   <= serin_wait_next;
      serout_wait  <= serout_wait_next;
      xmtdone_wait <= xmtdone_wait_next;
    end
  end

  // the line is raised only by a scanline tick
  a_irq_rise_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_line) |-> $past(proc && item.op == OP_TICK))
    else $error("irq line rose outside a scanline tick");

  // the line is dropped only by an irq enable write or reset
  a_irq_fall_on_irqen: assert property (@(posedge clk) disable iff (rst)
    $fell(irq_line) |-> $past(rst) ||
      $past(proc && item.op == OP_WRITE && item.address == ADDR_IRQEN))
    else $error("irq line fell outside an irq enable write");

  // a send needs the serial output mode selected
  a_send_mode: assert property (@(posedge clk) disable iff (rst)
    result.send_valid |-> (skctl & SKCTL_MODE_MASK) == SKCTL_MODE_SEND)
    else $error("send outside serial output mode");

endmodule

### sv/audio_timer_irq_controller.sv
// top level: stream channels, input and result registers, config registers
`timescale 1ns / 1ps
// Timer and interrupt section of a sound and I/O chip.
// Input stream: s_tuser carries the item kind (bus write, bus read or
// scanline tick); s_tdata carries address, write data, the received serial
// byte and the cassette delay. Output stream: one result per input item with
// the read byte (0xFF if not a read), the irq line after the item, and the
// send strobe and byte for a SEROUT write that passes the mode and speed checks.
// The config port holds the serial-out interval (0x0) and transmit-done
// interval (0x4), both in scanlines; write them only while the block is idle.
// An accepted item is held in the input register; its result is registered
// in the output register, where m_tvalid marks it. Throughput: one item per
// cycle while m_tready is high, bounded by the single pass through the state
// update between input and result registers. When m_tready is low the result
// holds, the input register still takes one more item, then s_tready drops
// until the result is taken.
// Reset clears both stages and loads the power-on register values; timer
// reloads start at one line.
module audio_timer_irq_controller #(
  parameter int CYCLES_PER_LINE = atic_pkg::CYCLES_PER_LINE_DEF,
  parameter int MULT_64K = atic_pkg::MULT_64K_DEF,
  parameter int MULT_15K = atic_pkg::MULT_15K_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // address[3:0], write_data[11:4],
                                 // serial_in_byte[19:12], cassette_delay[35:20]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // read_data[7:0], irq[8], send_valid[9], send_byte[17:10]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import atic_pkg::*;

  localparam logic CFG_SEROUT  = 1'b0;
  localparam logic CFG_XMTDONE = 1'b1;

  logic                  in_valid;
  item_t                 in_item;
  logic                  advance;
  logic                  proc;
  result_t               core_result;
  result_t               out_result;
  logic [INTERVAL_W-1:0] serout_ivl, xmtdone_ivl;
  logic                  cfg_write;

  assign advance  = !m_tvalid || m_tready;
  assign proc     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (proc) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op             <= op_t'(s_tuser);
      in_item.address        <= s_tdata[3:0];
      in_item.write_data     <= s_tdata[11:4];
      in_item.serial_in_byte <= s_tdata[19:12];
      in_item.cassette_delay <= s_tdata[35:20];
    end
    if (proc) begin
      out_result <= core_result;
    end
  end

  assign m_tdata = {6'h00, out_result.send_byte, out_result.send_valid,
                    out_result.irq, out_result.read_data};

  // config registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {16'h0000, (paddr[2] == CFG_XMTDONE) ? xmtdone_ivl : serout_ivl};

  always_ff @(posedge clk) begin
    if (rst) begin
      serout_ivl  <= INTERVAL_W'(900);
      xmtdone_ivl <= INTERVAL_W'(1500);
    end else if (cfg_write) begin
      if (paddr[2] == CFG_SEROUT) begin
        serout_ivl <= pwdata[INTERVAL_W-1:0];
      end else begin
        xmtdone_ivl <= pwdata[INTERVAL_W-1:0];
      end
    end
  end

  atic_core #(
    .CYCLES_PER_LINE (CYCLES_PER_LINE),
    .MULT_64K        (MULT_64K),
    .MULT_15K        (MULT_15K)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .proc        (proc),
    .item        (in_item),
    .serout_ivl  (serout_ivl),
    .xmtdone_ivl (xmtdone_ivl),
    .result      (core_result)
  );

  // an item leaving the input register always lands in the result register
  a_item_delivered: assert property (@(posedge clk) disable iff (rst)
    proc |=> m_tvalid)
    else $error("processed item produced no result");

  // send byte is zero unless a transfer to the serial peripheral is flagged
  a_send_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[9] |-> m_tdata[17:10] == 8'h00)
    else $error("send byte set without send strobe");

  // a stalled result stays put until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

endmodule
